// ===== hdl/utfl_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 line decoder.
package utfl_pkg;

    localparam int MAX_CHARS_DEFAULT = 64;
    localparam int COUNT_W           = 6;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD2_DATA  = 8'h1F;
    localparam logic [7:0] LEAD3_DATA  = 8'h0F;
    localparam logic [7:0] CONT_DATA   = 8'h3F;

    localparam logic [15:0] CHAR_LF      = 16'h000A;
    localparam logic [15:0] CHAR_CR      = 16'h000D;
    localparam logic [15:0] HEBREW_FIRST = 16'h05B0;
    localparam logic [15:0] HEBREW_LAST  = 16'h05EA;

    // One decoded event handed from the front to the back.
    typedef struct packed {
        logic        is_end;
        logic [15:0] cu;
    } evt_t;

endpackage

// ===== hdl/utfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module utfl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/utfl_front.sv =====
// Byte intake: UTF-8 sequence assembly, capacity limit and event generation.
module utfl_front #(
    parameter int MAX_CHARS = utfl_pkg::MAX_CHARS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     msg_byte,
    input  logic           msg_valid,
    output logic           msg_stall,
    input  logic           full,
    output logic           push,
    output utfl_pkg::evt_t push_evt
);

    localparam logic [utfl_pkg::COUNT_W-1:0] CAP = utfl_pkg::COUNT_W'(MAX_CHARS - 1);

    logic [7:0]                  lead_reg, lead_next;
    logic [7:0]                  cont_reg, cont_next;
    logic [1:0]                  need_reg, need_next;
    logic                        len3_reg, len3_next;
    logic [utfl_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                        pend_end_reg, pend_end_next;

    logic        accept;
    logic [15:0] cu2;
    logic [15:0] cu3;

    assign msg_stall = full | pend_end_reg;
    assign accept    = msg_valid & ~msg_stall;

    assign cu2 = {5'b0, lead_reg[4:0] & utfl_pkg::LEAD2_DATA[4:0],
                  msg_byte[5:0] & utfl_pkg::CONT_DATA[5:0]};
    assign cu3 = {lead_reg[3:0] & utfl_pkg::LEAD3_DATA[3:0],
                  cont_reg[5:0] & utfl_pkg::CONT_DATA[5:0],
                  msg_byte[5:0] & utfl_pkg::CONT_DATA[5:0]};

    always_comb
    begin
        lead_next     = lead_reg;
        cont_next     = cont_reg;
        need_next     = need_reg;
        len3_next     = len3_reg;
        total_next    = total_reg;
        pend_end_next = pend_end_reg;
        push          = 1'b0;
        push_evt      = '{is_end: 1'b0, cu: 16'h0000};

        if (pend_end_reg)
        begin
            if (!full)
            begin
                push          = 1'b1;
                push_evt      = '{is_end: 1'b1, cu: 16'h0000};
                pend_end_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (msg_byte == 8'h00)
            begin
                // cut three-byte sequence: an ASCII first continuation survives
                if (need_reg == 2'd1 && len3_reg && cont_reg < utfl_pkg::ASCII_LIMIT)
                begin
                    push_evt      = '{is_end: 1'b0, cu: {8'h00, cont_reg}};
                    pend_end_next = 1'b1;
                end
                else
                begin
                    push_evt = '{is_end: 1'b1, cu: 16'h0000};
                end
                push       = 1'b1;
                lead_next  = 8'h00;
                cont_next  = 8'h00;
                need_next  = 2'd0;
                len3_next  = 1'b0;
                total_next = '0;
            end
            else if (total_reg < CAP)
            begin
                if (need_reg == 2'd0)
                begin
                    if (msg_byte < utfl_pkg::ASCII_LIMIT)
                    begin
                        push       = 1'b1;
                        push_evt   = '{is_end: 1'b0, cu: {8'h00, msg_byte}};
                        total_next = total_reg + 1'b1;
                    end
                    else if ((msg_byte & utfl_pkg::LEAD2_MASK) == utfl_pkg::LEAD2_CODE)
                    begin
                        lead_next = msg_byte;
                        need_next = 2'd1;
                        len3_next = 1'b0;
                    end
                    else if ((msg_byte & utfl_pkg::LEAD3_MASK) == utfl_pkg::LEAD3_CODE)
                    begin
                        lead_next = msg_byte;
                        need_next = 2'd2;
                        len3_next = 1'b1;
                    end
                end
                else if (!len3_reg)
                begin
                    need_next  = 2'd0;
                    push       = 1'b1;
                    push_evt   = '{is_end: 1'b0, cu: cu2};
                    total_next = total_reg + 1'b1;
                end
                else if (need_reg == 2'd2)
                begin
                    cont_next = msg_byte;
                    need_next = 2'd1;
                end
                else
                begin
                    need_next  = 2'd0;
                    push       = 1'b1;
                    push_evt   = '{is_end: 1'b0, cu: cu3};
                    total_next = total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= 8'h00;
            cont_reg     <= 8'h00;
            need_reg     <= 2'd0;
            len3_reg     <= 1'b0;
            total_reg    <= '0;
            pend_end_reg <= 1'b0;
        end
        else
        begin
            lead_reg     <= lead_next;
            cont_reg     <= cont_next;
            need_reg     <= need_next;
            len3_reg     <= len3_next;
            total_reg    <= total_next;
            pend_end_reg <= pend_end_next;
        end
    end

endmodule

// ===== hdl/utfl_queue.sv =====
// Short event queue between the front and the back.
module utfl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  utfl_pkg::evt_t push_evt,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output utfl_pkg::evt_t head_evt
);

    localparam int PW = $clog2(utfl_pkg::QUEUE_DEPTH);

    utfl_pkg::evt_t slot [utfl_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == (PW+1)'(utfl_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_evt   = slot[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/utfl_back.sv =====
// Event execution: line-break holding, release, statistics and result register.
module utfl_back #(
    parameter int MAX_CHARS = utfl_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  utfl_pkg::evt_t                head_evt,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [15:0]                   code_unit,
    output logic                          is_last,
    output logic                          is_hebrew,
    output logic [utfl_pkg::COUNT_W-1:0]  char_count
);

    localparam int AW = $clog2(MAX_CHARS);
    localparam int CW = utfl_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RELEASE = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic          hebrew_reg, hebrew_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_cu_reg, out_cu_next;
    logic          out_last_reg, out_last_next;
    logic          out_heb_reg, out_heb_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;

    logic          out_free;
    logic          is_break;
    logic          in_hebrew;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;
    logic [CW-1:0] rd_idx_inc;

    assign out_free   = ~out_valid_reg | ~result_stall;
    assign is_break   = (head_evt.cu == utfl_pkg::CHAR_LF) | (head_evt.cu == utfl_pkg::CHAR_CR);
    assign in_hebrew  = (head_evt.cu >= utfl_pkg::HEBREW_FIRST) &
                        (head_evt.cu <= utfl_pkg::HEBREW_LAST);
    assign rd_idx_inc = rd_idx_reg + 1'b1;

    // one bit per held break: 1 for CR, 0 for LF
    utfl_ram #(
        .WIDTH(1),
        .DEPTH(MAX_CHARS)
    ) u_break_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (held_reg[AW-1:0]),
        .wdata (head_evt.cu == utfl_pkg::CHAR_CR),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        emitted_next   = emitted_reg;
        hebrew_next    = hebrew_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg & result_stall;
        out_cu_next    = out_cu_reg;
        out_last_next  = out_last_reg;
        out_heb_next   = out_heb_reg;
        out_cnt_next   = out_cnt_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_evt.is_end)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_cu_next    = 16'h0000;
                            out_last_next  = 1'b1;
                            out_heb_next   = hebrew_reg;
                            out_cnt_next   = emitted_reg;
                            pop            = 1'b1;
                            held_next      = '0;
                            emitted_next   = '0;
                            hebrew_next    = 1'b0;
                        end
                    end
                    else if (is_break)
                    begin
                        ram_we    = 1'b1;
                        held_next = held_reg + 1'b1;
                        pop       = 1'b1;
                    end
                    else if (held_reg != '0)
                    begin
                        // prefetch the first held break
                        ram_re      = 1'b1;
                        ram_raddr   = '0;
                        rd_idx_next = '0;
                        state_next  = S_RELEASE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_cu_next    = head_evt.cu;
                        out_last_next  = 1'b0;
                        out_heb_next   = 1'b0;
                        out_cnt_next   = '0;
                        pop            = 1'b1;
                        emitted_next   = emitted_reg + 1'b1;
                        hebrew_next    = hebrew_reg | in_hebrew;
                    end
                end
            end
            S_RELEASE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cu_next    = ram_rdata ? utfl_pkg::CHAR_CR : utfl_pkg::CHAR_LF;
                    out_last_next  = 1'b0;
                    out_heb_next   = 1'b0;
                    out_cnt_next   = '0;
                    emitted_next   = emitted_reg + 1'b1;
                    if (rd_idx_inc == held_reg)
                    begin
                        held_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_inc[AW-1:0];
                        rd_idx_next = rd_idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            emitted_reg   <= '0;
            hebrew_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            emitted_reg   <= emitted_next;
            hebrew_reg    <= hebrew_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cu_reg   <= out_cu_next;
        out_last_reg <= out_last_next;
        out_heb_reg  <= out_heb_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign result_valid = out_valid_reg;
    assign code_unit    = out_cu_reg;
    assign is_last      = out_last_reg;
    assign is_hebrew    = out_heb_reg;
    assign char_count   = out_cnt_reg;

endmodule

// ===== hdl/utf8_to_ucs2_line_decoder.sv =====
// Top level of the UTF-8 to UCS-2 line decoder.
// Takes one message byte per cycle on msg_valid/msg_stall and returns 16-bit
// code units on result_valid/result_stall, one word per kept character and a
// final word with is_last, the kept-character count and the Hebrew flag. The
// front decodes 1- to 3-byte sequences and feeds a four-entry event queue; the
// back holds CR/LF characters in a small break RAM and releases them ahead of
// the next ordinary character, dropping any still held at the terminator.
// Bytes go in at one per cycle while the queue has room and no end is pending.
// Releasing held breaks starts with a RAM read of the first one, then sends
// them out in order; a terminator after a cut three-byte sequence with an
// ASCII first continuation pushes that character, then the end event.
// At most MAX_CHARS-1 characters are kept per message.
module utf8_to_ucs2_line_decoder #(
    parameter int MAX_CHARS = utfl_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   msg_byte,
    input  logic                         msg_valid,
    output logic                         msg_stall,
    output logic [15:0]                  code_unit,
    output logic                         is_last,
    output logic                         is_hebrew,
    output logic [utfl_pkg::COUNT_W-1:0] char_count,
    output logic                         result_valid,
    input  logic                         result_stall
);

    logic           push;
    utfl_pkg::evt_t push_evt;
    logic           full;
    logic           pop;
    logic           head_valid;
    utfl_pkg::evt_t head_evt;

    utfl_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_byte  (msg_byte),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .full      (full),
        .push      (push),
        .push_evt  (push_evt)
    );

    utfl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_evt   (push_evt),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_evt   (head_evt)
    );

    utfl_back #(
        .MAX_CHARS(MAX_CHARS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_evt     (head_evt),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_unit    (code_unit),
        .is_last      (is_last),
        .is_hebrew    (is_hebrew),
        .char_count   (char_count)
    );

endmodule
